// ===== src/irt_pkg.sv =====
// Shared types and constants of the interrupt route table.
`timescale 1ns / 1ps
package irt_pkg;

  localparam int OvrDepth = 32;
  localparam int CtlDepth = 64;
  localparam int LocalLimit = 256;
  localparam int OvrAw = $clog2(OvrDepth);
  localparam int CtlAw = $clog2(CtlDepth);
  localparam int OvrCw = $clog2(OvrDepth + 1);
  localparam int CtlCw = $clog2(CtlDepth + 1);
  localparam int LocCw = $clog2(LocalLimit + 1);

  typedef enum logic [2:0] {
    REQ_CLEAR  = 3'd0,
    REQ_ADDCTL = 3'd1,
    REQ_ADDOVR = 3'd2,
    REQ_LOCAL  = 3'd3,
    REQ_FINISH = 3'd4,
    REQ_QUERY  = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTREADY = 2'd1,
    ST_NOLOCAL  = 2'd2,
    ST_NOCTL    = 2'd3
  } status_t;

  // Work handed from the front part to the back part.
  typedef struct packed {
    logic [2:0]  req;
    logic [7:0]  bus;
    logic [2:0]  legacy;
    logic [7:0]  src;
    logic [31:0] inum;
    logic [7:0]  cid;
    logic [8:0]  lcount;
    logic        low;
    logic        level;
    logic        lookup;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  legacy_line;
    logic [31:0] global_line;
    logic [7:0]  target_controller;
    logic [7:0]  target_pin;
    logic        is_active_low;
    logic        is_level;
    logic        overridden;
  } res_t;

endpackage

// ===== src/irt_front.sv =====
// Front part: accepts items, decodes them and queues them for the engine.
`timescale 1ns / 1ps
module irt_front import irt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  req_type,
  input  logic [7:0]  bus_number,
  input  logic [4:0]  device_number,
  input  logic [2:0]  pin_number,
  input  logic [7:0]  source_line,
  input  logic [31:0] interrupt_number,
  input  logic [7:0]  controller_id,
  input  logic [8:0]  line_count,
  input  logic [15:0] polarity_flags,
  input  logic        line_lookup,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_take
);

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       c;
  logic [4:0] leg5;
  logic       do_push, do_pop;

  assign leg5 = {device_number[2:0], 2'b00} + {2'b00, pin_number} - 5'd1;

  always_comb begin
    c.req    = req_type;
    c.bus    = bus_number;
    c.legacy = leg5[2:0];
    c.src    = source_line;
    c.inum   = interrupt_number;
    c.cid    = controller_id;
    c.lcount = line_count;
    c.low    = polarity_flags[1];
    c.level  = polarity_flags[3];
    c.lookup = line_lookup;
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= c;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  a_nopop: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !do_pop) else $error("pop from empty queue");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> wp_r == rp_r)
    else $error("queue pointers disagree with count");

endmodule

// ===== src/irt_engine.sv =====
// Back part: table storage, sequential scans and the result register.
`timescale 1ns / 1ps
module irt_engine import irt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  cmd_valid,
  input  cmd_t  cmd,
  output logic  cmd_take,
  output logic  res_valid,
  output res_t  res,
  input  logic  res_take
);

  typedef enum logic [2:0] {S_IDLE, S_OVR, S_OVR_CHK, S_CTL, S_CTL_CHK, S_DONE} state_t;

  logic [49:0] ovr_mem [OvrDepth];
  logic [48:0] ctl_mem [CtlDepth];
  logic [49:0] ovr_rd_r;
  logic [48:0] ctl_rd_r;

  state_t          state_r;
  logic [OvrCw-1:0] ofill_r;
  logic [CtlCw-1:0] cfill_r;
  logic [LocCw-1:0] lfill_r;
  logic             ready_r;
  cmd_t             cur_r;
  logic [OvrCw-1:0] oi_r;
  logic [CtlCw-1:0] ci_r;
  res_t             wrk_r;
  res_t             res_r;
  logic             res_valid_r;

  logic        omatch;
  logic [32:0] cend;
  logic [31:0] cbase;
  logic        chit;
  logic [31:0] diff;
  logic        out_load;

  assign cmd_take  = (state_r == S_IDLE) && cmd_valid;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  // The finished result moves to the output register once that register is free.
  assign out_load  = (state_r == S_DONE) && (!res_valid_r || res_take);

  // Override entry: bus, src, gline, low, level.
  assign omatch = (ovr_rd_r[41:34] == (cur_r.lookup ? cur_r.src : {5'd0, cur_r.legacy}))
                  && (cur_r.lookup || ovr_rd_r[49:42] == cur_r.bus);
  assign cbase  = ctl_rd_r[40:9];
  assign cend   = {1'b0, cbase} + {24'd0, ctl_rd_r[8:0]};
  assign chit   = ({1'b0, wrk_r.global_line} >= {1'b0, cbase})
                  && ({1'b0, wrk_r.global_line} < cend);
  assign diff   = wrk_r.global_line - cbase;

  always_ff @(posedge clk) begin
    if (cmd_take && cmd.req == REQ_ADDOVR && ofill_r < OvrCw'(OvrDepth))
      ovr_mem[ofill_r[OvrAw-1:0]] <= {cmd.bus, cmd.src, cmd.inum, cmd.low, cmd.level};
    if (cmd_take && cmd.req == REQ_ADDCTL && cfill_r < CtlCw'(CtlDepth))
      ctl_mem[cfill_r[CtlAw-1:0]] <= {cmd.cid, cmd.inum, cmd.lcount};
    ovr_rd_r <= ovr_mem[oi_r[OvrAw-1:0]];
    ctl_rd_r <= ctl_mem[ci_r[CtlAw-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ofill_r <= '0;
      cfill_r <= '0;
      lfill_r <= '0;
      ready_r <= 1'b0;
      res_valid_r <= 1'b0;
      oi_r <= '0;
      ci_r <= '0;
    end else begin
      if (out_load) res_valid_r <= 1'b1;
      else if (res_valid_r && res_take) res_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cur_r <= cmd;
            wrk_r <= '0;
            oi_r <= '0;
            ci_r <= '0;
            state_r <= S_DONE;
            priority case (cmd.req)
              REQ_CLEAR: begin
                ofill_r <= '0;
                cfill_r <= '0;
                lfill_r <= '0;
                ready_r <= 1'b0;
              end
              REQ_ADDCTL: if (cfill_r < CtlCw'(CtlDepth)) cfill_r <= cfill_r + CtlCw'(1);
              REQ_ADDOVR: if (ofill_r < OvrCw'(OvrDepth)) ofill_r <= ofill_r + OvrCw'(1);
              REQ_LOCAL: if (lfill_r < LocCw'(LocalLimit)) lfill_r <= lfill_r + LocCw'(1);
              REQ_FINISH: begin
                ready_r <= 1'b0;
                if (lfill_r == '0) wrk_r.status <= ST_NOLOCAL;
                else if (cfill_r == '0) wrk_r.status <= ST_NOCTL;
                else ready_r <= 1'b1;
              end
              REQ_QUERY: begin
                if (!ready_r) wrk_r.status <= ST_NOTREADY;
                else begin
                  wrk_r.global_line <= cmd.lookup ? {24'd0, cmd.src}
                                                  : {29'd0, cmd.legacy};
                  if (!cmd.lookup) begin
                    wrk_r.legacy_line <= cmd.legacy;
                    wrk_r.target_pin <= {5'd0, cmd.legacy};
                  end
                  state_r <= S_OVR;
                end
              end
              default: ;
            endcase
          end
        end
        S_OVR: begin
          if (oi_r < ofill_r) state_r <= S_OVR_CHK;
          else state_r <= cur_r.lookup ? S_DONE : S_CTL;
        end
        S_OVR_CHK: begin
          if (omatch) begin
            wrk_r.global_line <= ovr_rd_r[33:2];
            wrk_r.is_active_low <= ovr_rd_r[1];
            wrk_r.is_level <= ovr_rd_r[0];
            wrk_r.overridden <= 1'b1;
            state_r <= cur_r.lookup ? S_DONE : S_CTL;
          end else begin
            oi_r <= oi_r + OvrCw'(1);
            state_r <= S_OVR;
          end
        end
        S_CTL: begin
          if (ci_r < cfill_r) state_r <= S_CTL_CHK;
          else state_r <= S_DONE;
        end
        S_CTL_CHK: begin
          if (chit) begin
            wrk_r.target_controller <= ctl_rd_r[48:41];
            wrk_r.target_pin <= diff[7:0];
            state_r <= S_DONE;
          end else begin
            ci_r <= ci_r + CtlCw'(1);
            state_r <= S_CTL;
          end
        end
        S_DONE: begin
          if (out_load) begin
            res_r <= wrk_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_ofill: assert property (@(posedge clk) disable iff (!rst_n)
    ofill_r <= OvrCw'(OvrDepth)) else $error("override fill overflow");
  a_cfill: assert property (@(posedge clk) disable iff (!rst_n)
    cfill_r <= CtlCw'(CtlDepth)) else $error("controller fill overflow");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> (lfill_r != '0 && cfill_r != '0)) else $error("ready without tables");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |=> state_r != S_IDLE) else $error("command taken but engine idle");

endmodule

// ===== src/interrupt_route_table_core.sv =====
// Top level of the interrupt route table.
// Items enter through in_push/in_full like a queue; an item transfers at a
// clock edge with in_push high and in_full low. Every item yields exactly one
// result, shown on the out_ ports while out_empty is low and taken by a
// transfer with out_pop high. A two-entry queue decouples the decoder from
// the engine, and a result register lets the next item start while a result
// waits. A load item goes from the engine's idle state straight to done, and
// the engine takes no new item until that result has moved into the result
// register. A route query scans the override table entry by entry through
// S_OVR and S_OVR_CHK, then the controller table through S_CTL and S_CTL_CHK;
// each table has a single read port. A line lookup skips the controller scan.
// Synchronous reset empties the queue and zeroes the fill counts and the
// ready flag; table contents are not cleared. When the receiver stalls the
// engine holds its finished result, then the queue fills and in_full rises.
`timescale 1ns / 1ps
module interrupt_route_table_core import irt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_bus_number,
  input  logic [4:0]  in_device_number,
  input  logic [2:0]  in_pin_number,
  input  logic [7:0]  in_source_line,
  input  logic [31:0] in_interrupt_number,
  input  logic [7:0]  in_controller_id,
  input  logic [8:0]  in_line_count,
  input  logic [15:0] in_polarity_flags,
  input  logic        in_line_lookup,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_status,
  output logic [2:0]  out_legacy_line,
  output logic [31:0] out_global_line,
  output logic [7:0]  out_target_controller,
  output logic [7:0]  out_target_pin,
  output logic        out_is_active_low,
  output logic        out_is_level,
  output logic        out_overridden
);

  logic cmd_valid, cmd_take, res_valid;
  cmd_t cmd;
  res_t res;

  irt_front u_front (
    .clk, .rst_n, .push(in_push), .full(in_full),
    .req_type(in_req_type), .bus_number(in_bus_number),
    .device_number(in_device_number), .pin_number(in_pin_number),
    .source_line(in_source_line), .interrupt_number(in_interrupt_number),
    .controller_id(in_controller_id), .line_count(in_line_count),
    .polarity_flags(in_polarity_flags), .line_lookup(in_line_lookup),
    .cmd_valid, .cmd, .cmd_take
  );

  irt_engine u_engine (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_take,
    .res_valid, .res, .res_take(out_pop)
  );

  assign out_empty             = !res_valid;
  assign out_status            = res.status;
  assign out_legacy_line       = res.legacy_line;
  assign out_global_line       = res.global_line;
  assign out_target_controller = res.target_controller;
  assign out_target_pin        = res.target_pin;
  assign out_is_active_low     = res.is_active_low;
  assign out_is_level          = res.is_level;
  assign out_overridden        = res.overridden;

endmodule
